// ===== rtl/lrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpc_pkg
// shared constants, types and helpers for the ring point clusterer
// ----------------------------------------------------------------------------
package lrpc_pkg;

    localparam int MAX_CLUSTERS_DEF = 256;
    localparam int NUM_RINGS_DEF    = 32;
    localparam int COORD_W          = 24;
    localparam int RING_W           = 5;
    localparam int INDEX_W          = 16;
    localparam int THRESH_W         = 16;
    localparam int CNUM_W           = 8;
    localparam int STATUS_W         = 2;
    localparam int BOUNDS_W         = 6 * COORD_W + 2 * RING_W;
    localparam int RANGE_W          = 2 * INDEX_W;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd256;

    localparam logic [STATUS_W-1:0] ST_JOINED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPENED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] front_x;
        logic signed [COORD_W-1:0] back_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] right_y;
        logic signed [COORD_W-1:0] top_z;
        logic signed [COORD_W-1:0] bottom_z;
        logic [RING_W-1:0]         high_ring;
        logic [RING_W-1:0]         low_ring;
    } clus_t;

    typedef struct packed {
        logic [INDEX_W-1:0] lo;
        logic [INDEX_W-1:0] hi;
    } span_t;

    // saturate a 26-bit sum to the 24-bit coordinate range
    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [COORD_W+1:0] v);
        logic signed [COORD_W+1:0] vmax;
        logic signed [COORD_W+1:0] vmin;
        vmax = 26'sd8388607;
        vmin = -26'sd8388608;
        if (v > vmax)
            sat24 = 24'sh7FFFFF;
        else if (v < vmin)
            sat24 = 24'sh800000;
        else
            sat24 = v[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/lidar_ring_point_clusterer.sv =====
// ----------------------------------------------------------------------------
// lidar_ring_point_clusterer
// assigns lidar edge points to bounding-box clusters, one request at a time
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then reads
// the stored clusters through the cluster ram and a single compare unit, in
// creation order, one cluster at a time (address cycle, then compare cycle),
// stopping at the first match. The result appears on the output ports for
// exactly one cycle with done high, the first cycle after busy falls, and a
// new request can be taken at the edge that ends it; the receiver cannot
// stall it. Per-ring index ranges live in a ram of MAX_CLUSTERS*NUM_RINGS
// rows tagged with the frame tag of their cluster, the cluster's tag held in
// a small ram, so opening a cluster needs no clearing sweep. The range ram
// tags are swept to zero after reset and again on every 255th start_frame
// request, when the frame tag wraps; busy then stays high through a sweep of
// all MAX_CLUSTERS*NUM_RINGS rows (8192 by default).
module lidar_ring_point_clusterer #(
    parameter int MAX_CLUSTERS = lrpc_pkg::MAX_CLUSTERS_DEF,
    parameter int NUM_RINGS    = lrpc_pkg::NUM_RINGS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               start_frame,
    input  logic signed [lrpc_pkg::COORD_W-1:0] pos_x,
    input  logic signed [lrpc_pkg::COORD_W-1:0] pos_y,
    input  logic signed [lrpc_pkg::COORD_W-1:0] pos_z,
    input  logic [lrpc_pkg::RING_W-1:0]        ring_num,
    input  logic [lrpc_pkg::INDEX_W-1:0]       scan_index,
    // config channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lrpc_pkg::THRESH_W-1:0]      cfg_data,
    // result channel
    output logic                               done,
    output logic [lrpc_pkg::CNUM_W-1:0]        cluster_num,
    output logic [lrpc_pkg::STATUS_W-1:0]      status,
    output logic signed [lrpc_pkg::COORD_W-1:0] front_x,
    output logic signed [lrpc_pkg::COORD_W-1:0] back_x,
    output logic signed [lrpc_pkg::COORD_W-1:0] left_y,
    output logic signed [lrpc_pkg::COORD_W-1:0] right_y,
    output logic signed [lrpc_pkg::COORD_W-1:0] top_z,
    output logic signed [lrpc_pkg::COORD_W-1:0] bottom_z,
    output logic [lrpc_pkg::RING_W-1:0]        high_ring,
    output logic [lrpc_pkg::RING_W-1:0]        low_ring,
    output logic [lrpc_pkg::INDEX_W-1:0]       ring_min_index,
    output logic [lrpc_pkg::INDEX_W-1:0]       ring_max_index
);

    localparam int CA_W   = $clog2(MAX_CLUSTERS);
    localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int RG_W   = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int RDEPTH = MAX_CLUSTERS * NUM_RINGS;
    localparam int RA_W   = $clog2(RDEPTH);
    localparam int EP_W   = 8;
    // range row: epoch tag then lo/hi
    localparam int RR_W   = EP_W + lrpc_pkg::RANGE_W;
    localparam int CW     = lrpc_pkg::COORD_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;  // cluster address presented
    localparam logic [2:0] S_TEST  = 3'd2;  // cluster data back, compare
    localparam logic [2:0] S_RNG   = 3'd3;  // range row address presented
    localparam logic [2:0] S_WAIT  = 3'd4;  // range row data back
    localparam logic [2:0] S_DONE  = 3'd5;  // write back, show result
    localparam logic [2:0] S_CLR   = 3'd6;  // sweep range row tags to zero

    logic [2:0]                     state_reg, state_next;
    logic [lrpc_pkg::THRESH_W-1:0]  thresh_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CA_W-1:0]                idx_reg;
    logic [EP_W-1:0]                epoch_reg;   // 1 to 255, bumps on each start_frame
    logic                           found_reg;
    logic                           opened_reg;
    logic [RA_W-1:0]                clr_reg;     // sweep address
    logic                           boot_reg;    // sweep after reset, no request held

    // latched request
    logic signed [CW-1:0]           px_reg, py_reg, pz_reg;
    logic [lrpc_pkg::RING_W-1:0]    ring_reg;
    logic [lrpc_pkg::INDEX_W-1:0]   sidx_reg;
    lrpc_pkg::clus_t                clus_reg;   // updated cluster record
    logic [EP_W-1:0]                cep_reg;    // epoch tag of this cluster

    // rams
    logic                           cl_we;
    logic [CA_W-1:0]                cl_addr_w, cl_addr_r;
    lrpc_pkg::clus_t                cl_wdata, cl_rdata;
    logic                           ep_we;
    logic [EP_W-1:0]                ep_rdata;
    logic                           rr_we;
    logic [RA_W-1:0]                rr_addr;
    logic [RR_W-1:0]                rr_wdata, rr_rdata;

    logic                           hit;
    logic                           in_range;
    logic [RG_W-1:0]                ring_sel;
    logic signed [CW+1:0]           t26;
    lrpc_pkg::clus_t                upd;
    logic [lrpc_pkg::INDEX_W-1:0]   rmin, rmax;
    logic                           row_used;
    logic [CNT_W-1:0]               count_eff;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign t26 = $signed({{(CW+2-lrpc_pkg::THRESH_W){1'b0}}, thresh_reg});

    // rings past NUM_RINGS keep no range
    assign in_range = ({{(32-lrpc_pkg::RING_W){1'b0}}, ring_reg} < NUM_RINGS);
    assign ring_sel = RG_W'(ring_reg);
    // tag 0 marks a cleared row, never a live frame tag
    assign rr_addr  = (state_reg == S_CLR) ? clr_reg
                    : RA_W'(idx_reg) * RA_W'(NUM_RINGS) + RA_W'(ring_sel);

    lrpc_ram #(.WIDTH(lrpc_pkg::BOUNDS_W), .DEPTH(MAX_CLUSTERS)) u_clus (
        .clk(clk), .we(cl_we), .waddr(cl_addr_w), .wdata(cl_wdata),
        .raddr(cl_addr_r), .rdata(cl_rdata)
    );

    lrpc_ram #(.WIDTH(EP_W), .DEPTH(MAX_CLUSTERS)) u_epoch (
        .clk(clk), .we(ep_we), .waddr(idx_reg), .wdata(epoch_reg),
        .raddr(idx_reg), .rdata(ep_rdata)
    );

    lrpc_ram #(.WIDTH(RR_W), .DEPTH(RDEPTH)) u_range (
        .clk(clk), .we(rr_we), .waddr(rr_addr), .wdata(rr_wdata),
        .raddr(rr_addr), .rdata(rr_rdata)
    );

    lrpc_match u_match (
        .clus(cl_rdata), .px(px_reg), .py(py_reg), .ring(ring_reg),
        .thresh(thresh_reg), .hit(hit)
    );

    assign cl_addr_r = idx_reg;
    assign cl_addr_w = idx_reg;
    assign cl_wdata  = clus_reg;

    // widen bounds of a matched cluster around the point, or set a new cluster's bounds around it
    always_comb
    begin
        logic signed [CW-1:0] xp, xm, yp, ym, zp, zm;
        xp = lrpc_pkg::sat24({{2{px_reg[CW-1]}}, px_reg} + t26);
        xm = lrpc_pkg::sat24({{2{px_reg[CW-1]}}, px_reg} - t26);
        yp = lrpc_pkg::sat24({{2{py_reg[CW-1]}}, py_reg} + t26);
        ym = lrpc_pkg::sat24({{2{py_reg[CW-1]}}, py_reg} - t26);
        zp = lrpc_pkg::sat24({{2{pz_reg[CW-1]}}, pz_reg} + t26);
        zm = lrpc_pkg::sat24({{2{pz_reg[CW-1]}}, pz_reg} - t26);
        upd = cl_rdata;
        if (ring_reg < upd.low_ring)  upd.low_ring  = ring_reg;
        if (ring_reg > upd.high_ring) upd.high_ring = ring_reg;
        if (xp > upd.front_x)  upd.front_x  = xp;
        if (xm < upd.back_x)   upd.back_x   = xm;
        if (yp > upd.left_y)   upd.left_y   = yp;
        if (ym < upd.right_y)  upd.right_y  = ym;
        if (zp > upd.top_z)    upd.top_z    = zp;
        if (zm < upd.bottom_z) upd.bottom_z = zm;
        if (!found_reg)
        begin
            upd.front_x   = xp;
            upd.back_x    = xm;
            upd.left_y    = yp;
            upd.right_y   = ym;
            upd.top_z     = zp;
            upd.bottom_z  = zm;
            upd.high_ring = ring_reg;
            upd.low_ring  = ring_reg;
        end
    end

    // range row: valid when its tag matches the cluster's creation tag
    assign row_used = (rr_rdata[RR_W-1 -: EP_W] == cep_reg);
    always_comb
    begin
        logic [lrpc_pkg::INDEX_W-1:0] lo, hi;
        lo = rr_rdata[lrpc_pkg::RANGE_W-1 -: lrpc_pkg::INDEX_W];
        hi = rr_rdata[lrpc_pkg::INDEX_W-1:0];
        if (!row_used || !in_range)
        begin
            rmin = sidx_reg;
            rmax = sidx_reg;
        end
        else
        begin
            rmin = (sidx_reg < lo) ? sidx_reg : lo;
            rmax = (sidx_reg > hi) ? sidx_reg : hi;
        end
    end

    assign count_eff = count_reg;

    // ram writes happen in the done cycle, or every cycle of a sweep
    always_comb
    begin
        cl_we    = 1'b0;
        ep_we    = 1'b0;
        rr_we    = 1'b0;
        rr_wdata = {cep_reg, rmin, rmax};
        if (state_reg == S_DONE && (found_reg || opened_reg))
        begin
            cl_we = 1'b1;
            ep_we = opened_reg;
            rr_we = in_range;
        end
        if (state_reg == S_CLR)
        begin
            rr_we    = 1'b1;
            rr_wdata = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (start_frame && epoch_reg == '1) ? S_CLR : S_READ;
            S_CLR:
                if (clr_reg == RA_W'(RDEPTH - 1))
                    state_next = boot_reg ? S_IDLE : S_READ;
            S_READ:
                if ({1'b0, idx_reg} >= {1'b0, count_eff} || count_eff == '0)
                    state_next = S_RNG;
                else
                    state_next = S_TEST;
            S_TEST:
                if (hit || {{(CNT_W-CA_W){1'b0}}, idx_reg} + 1'b1 >= count_eff)
                    state_next = S_RNG;
                else
                    state_next = S_READ;
            S_RNG:  state_next = S_WAIT;
            S_WAIT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            thresh_reg <= lrpc_pkg::THRESH_RESET;
            count_reg  <= '0;
            idx_reg    <= '0;
            epoch_reg  <= EP_W'(1);
            found_reg  <= 1'b0;
            opened_reg <= 1'b0;
            clr_reg    <= '0;
            boot_reg   <= 1'b1;
            done       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            if (cfg_valid && cfg_ready)
                thresh_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        opened_reg <= 1'b0;
                        if (start_frame)
                        begin
                            count_reg <= '0;
                            // tag wraps back to 1, the sweep clears old rows
                            epoch_reg <= (epoch_reg == '1) ? EP_W'(1) : epoch_reg + 1'b1;
                        end
                    end
                S_CLR:
                    if (clr_reg == RA_W'(RDEPTH - 1))
                    begin
                        clr_reg  <= '0;
                        boot_reg <= 1'b0;
                    end
                    else
                        clr_reg <= clr_reg + 1'b1;
                S_READ: ;
                S_TEST:
                    if (hit)
                        found_reg <= 1'b1;
                    else if ({{(CNT_W-CA_W){1'b0}}, idx_reg} + 1'b1 < count_eff)
                        idx_reg <= idx_reg + 1'b1;
                S_RNG:
                    // no match: open a new cluster at the count while there is room
                    if (!found_reg && count_reg < CNT_W'(MAX_CLUSTERS))
                    begin
                        opened_reg <= 1'b1;
                        idx_reg    <= CA_W'(count_reg);
                    end
                S_WAIT: ;
                S_DONE:
                begin
                    done <= 1'b1;
                    if (opened_reg)
                        count_reg <= count_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            ring_reg <= ring_num;
            sidx_reg <= scan_index;
        end
        if (state_reg == S_WAIT)
        begin
            clus_reg <= upd;
            cep_reg  <= opened_reg ? epoch_reg : ep_rdata;
        end
        if (state_reg == S_DONE)
        begin
            if (found_reg || opened_reg)
            begin
                cluster_num    <= lrpc_pkg::CNUM_W'(idx_reg);
                status         <= found_reg ? lrpc_pkg::ST_JOINED : lrpc_pkg::ST_OPENED;
                front_x        <= clus_reg.front_x;
                back_x         <= clus_reg.back_x;
                left_y         <= clus_reg.left_y;
                right_y        <= clus_reg.right_y;
                top_z          <= clus_reg.top_z;
                bottom_z       <= clus_reg.bottom_z;
                high_ring      <= clus_reg.high_ring;
                low_ring       <= clus_reg.low_ring;
                ring_min_index <= rmin;
                ring_max_index <= rmax;
            end
            else
            begin
                cluster_num    <= '0;
                status         <= lrpc_pkg::ST_DROPPED;
                front_x        <= '0;
                back_x         <= '0;
                left_y         <= '0;
                right_y        <= '0;
                top_z          <= '0;
                bottom_z       <= '0;
                high_ring      <= '0;
                low_ring       <= '0;
                ring_min_index <= '0;
                ring_max_index <= '0;
            end
        end
    end

endmodule

// ===== rtl/lrpc_ram.sv =====
// ----------------------------------------------------------------------------
// lrpc_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module lrpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lrpc_match.sv =====
// ----------------------------------------------------------------------------
// lrpc_match
// shared compare unit: tests one stored cluster against the point
// ----------------------------------------------------------------------------
module lrpc_match (
    input  lrpc_pkg::clus_t                  clus,
    input  logic signed [lrpc_pkg::COORD_W-1:0] px,
    input  logic signed [lrpc_pkg::COORD_W-1:0] py,
    input  logic [lrpc_pkg::RING_W-1:0]      ring,
    input  logic [lrpc_pkg::THRESH_W-1:0]    thresh,
    output logic                             hit
);

    logic signed [lrpc_pkg::COORD_W+1:0] t;
    logic signed [lrpc_pkg::COORD_W+1:0] x;
    logic signed [lrpc_pkg::COORD_W+1:0] y;
    // stored bounds widened to the compare width, kept signed
    logic signed [lrpc_pkg::COORD_W+1:0] fx;
    logic signed [lrpc_pkg::COORD_W+1:0] bx;
    logic signed [lrpc_pkg::COORD_W+1:0] ly;
    logic signed [lrpc_pkg::COORD_W+1:0] ry;
    logic ring_ok;

    assign t = $signed({{(lrpc_pkg::COORD_W+2-lrpc_pkg::THRESH_W){1'b0}}, thresh});
    assign x = {{2{px[lrpc_pkg::COORD_W-1]}}, px};
    assign y = {{2{py[lrpc_pkg::COORD_W-1]}}, py};

    assign fx = {{2{clus.front_x[lrpc_pkg::COORD_W-1]}}, clus.front_x};
    assign bx = {{2{clus.back_x[lrpc_pkg::COORD_W-1]}}, clus.back_x};
    assign ly = {{2{clus.left_y[lrpc_pkg::COORD_W-1]}}, clus.left_y};
    assign ry = {{2{clus.right_y[lrpc_pkg::COORD_W-1]}}, clus.right_y};

    // low ring zero only matches ring zero
    assign ring_ok = (ring == clus.low_ring)
                  || ((clus.low_ring != '0) && (ring == clus.low_ring - 1'b1));

    always_comb
    begin
        hit = ring_ok
           && (x < (fx + t))
           && ((bx - t) < x)
           && (y < (ly + t))
           && ((ry - t) < y);
    end

endmodule
